// ===== hw/rtl/sactl_pkg.sv =====
// ----------------------------------------------------------------------------
// sactl_pkg: shared sizes and types for the set-associative tag store
// Address split, line and row layouts, and the field helpers used by the
// tag store; the checker takes only the output width from here.
// ----------------------------------------------------------------------------
package sactl_pkg;

    // derive floor of log2 at elaboration
    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // cache geometry
    localparam int WAYS            = 2;
    localparam int WORDS_PER_BLOCK = 4;
    localparam int CACHE_WORDS     = 256;

    localparam int SETS_RAW = CACHE_WORDS / WORDS_PER_BLOCK / WAYS;
    localparam int SETS     = (SETS_RAW == 0) ? 1 : SETS_RAW;
    localparam int SET_BITS = floor_log2(SETS);
    localparam int SET_OFF  = 2 + floor_log2(WORDS_PER_BLOCK);
    localparam int TAG_OFF  = SET_OFF + SET_BITS;

    localparam int ADDR_W  = 32;
    localparam int TAG_W   = ADDR_W - TAG_OFF;
    localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int ROWS    = 1 << SET_BITS;
    localparam int AGE_W   = $clog2(WAYS + 1);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [SET_W-1:0] t_set;
    typedef logic [AGE_W-1:0] t_age;
    typedef logic [WAY_W-1:0] t_way_idx;

    // one way of a set
    typedef struct packed {
        t_tag tag;
        t_age age;
        logic valid;
        logic dirty;
    } t_line;

    // all ways of one set, stored as one memory row
    typedef t_line [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // pull the set index out of a byte address
    function automatic t_set get_set(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] sh;
        sh = addr >> SET_OFF;
        if (SET_BITS == 0) begin
            return '0;
        end
        return sh[SET_W-1:0];
    endfunction

    // pull the tag out of a byte address
    function automatic t_tag get_tag(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] sh;
        sh = addr >> TAG_OFF;
        return sh[TAG_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/sactl_ram.sv =====
// ----------------------------------------------------------------------------
// sactl_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sactl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/set_assoc_cache_tag_lru.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru: tag store of a set-associative cache, counter LRU
// A request accepted is held in the input stage while its set is read from
// the tag RAM, then its result is registered in the result stage.
// Throughput: one request per cycle unless the output stalls; each set is
// one row of the tag RAM, read at accept and written back as the request
// leaves the input stage, with a bypass for back-to-back same-set requests.
// Reset: one valid flag per set is cleared at once, so every line reads as
// empty; no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] address
    input  logic [sactl_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] is_write
    input  logic [sactl_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] miss, [1] evict, [2] wback, [7:3] zero
    output logic [sactl_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import sactl_pkg::*;

    // input stage
    logic        r_s1_vld;
    t_set        r_s1_set;
    t_tag        r_s1_tag;
    logic        r_s1_wr;
    logic        r_s1_rv;
    logic        r_byp;
    t_row        r_byp_row;

    // set valid flags
    logic [ROWS-1:0] r_row_vld;

    // result stage
    logic        r_out_vld;
    logic        r_miss;
    logic        r_evict;
    logic        r_wb;

    logic        in_fire;
    logic        s1_adv;
    logic        wr_en;
    t_set        in_set;
    t_row        ram_rdata;
    t_row        cur_row;
    t_row        n_row;
    logic        n_miss;
    logic        n_evict;
    logic        n_wb;

    logic        hit_found;
    t_way_idx    hit_way;
    logic        inv_found;
    t_way_idx    inv_way;
    t_way_idx    lru_way;
    t_age        lru_age;
    t_way_idx    vic_way;

    // handshake
    assign s1_adv          = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_en           = r_s1_vld && s1_adv;
    assign in_set          = get_set(i_s_axis_tdata[ADDR_W-1:0]);

    sactl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_set),
        .i_wdata (n_row),
        .i_re    (in_fire),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // select current set contents: bypass, stored row, or empty
    always_comb begin
        if (r_byp) begin
            cur_row = r_byp_row;
        end else if (r_s1_rv) begin
            cur_row = ram_rdata;
        end else begin
            cur_row = '0;
        end
    end

    // look up the set: first valid match, first empty way, first oldest way
    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        lru_age   = cur_row[0].age;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_found && cur_row[w].valid && cur_row[w].tag == r_s1_tag) begin
                hit_found = 1'b1;
                hit_way   = t_way_idx'(w);
            end
            if (!inv_found && !cur_row[w].valid) begin
                inv_found = 1'b1;
                inv_way   = t_way_idx'(w);
            end
            if (w > 0 && cur_row[w].age < lru_age) begin
                lru_age = cur_row[w].age;
                lru_way = t_way_idx'(w);
            end
        end
    end

    // update the set and form the result
    always_comb begin
        n_row   = cur_row;
        n_miss  = 1'b0;
        n_evict = 1'b0;
        n_wb    = 1'b0;
        vic_way = inv_found ? inv_way : lru_way;
        if (hit_found) begin
            for (int w = 0; w < WAYS; w++) begin
                if (cur_row[w].age != '0) begin
                    n_row[w].age = cur_row[w].age - t_age'(1);
                end
            end
            n_row[hit_way].age   = t_age'(WAYS);
            n_row[hit_way].dirty = cur_row[hit_way].dirty | r_s1_wr;
        end else begin
            n_miss               = 1'b1;
            n_evict              = !inv_found;
            n_wb                 = !inv_found && cur_row[lru_way].dirty;
            n_row[vic_way].tag   = r_s1_tag;
            n_row[vic_way].age   = t_age'(WAYS);
            n_row[vic_way].valid = 1'b1;
            n_row[vic_way].dirty = r_s1_wr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_byp     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_vld <= 1'b1;
                r_byp    <= wr_en && (r_s1_set == in_set);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (wr_en) begin
                r_row_vld[r_s1_set] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_set  <= in_set;
            r_s1_tag  <= get_tag(i_s_axis_tdata[ADDR_W-1:0]);
            r_s1_wr   <= i_s_axis_tuser[0];
            r_s1_rv   <= r_row_vld[in_set];
            r_byp_row <= n_row;
        end
        if (s1_adv) begin
            r_miss  <= n_miss;
            r_evict <= n_evict;
            r_wb    <= n_wb;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b00000, r_wb, r_evict, r_miss};

endmodule

// ===== hw/rtl/sactl_checker.sv =====
// ----------------------------------------------------------------------------
// sactl_checker: port-level checks for the tag store
// Watches the stream ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module sactl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [sactl_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // drop results during reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // accept requests whenever the output is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // an eviction is always a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[0])
        else $error("evict without miss");

    // a write-back always comes with an eviction
    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2] |-> o_m_axis_tdata[1])
        else $error("write-back without evict");

endmodule

bind set_assoc_cache_tag_lru sactl_checker u_sactl_checker (.*);

// ===== test/set_assoc_cache_tag_lru_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_tb: self-checking bench for the cache tag store
// Drives address/write requests over the input stream and predicts every
// miss/evict/write-back result with a shadow copy of the tags, age counters,
// valid and dirty bits. Directed cases come first, then random traffic on a
// few hot sets under bursty input, stalling output and a long hold-off.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sactl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 8;
    localparam int OFF_SPAN    = 1 << SET_OFF;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct packed {
        logic wback;
        logic evict;
        logic miss;
    } t_lookup_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_TDATA_W-1:0]    i_s_axis_tdata = '0;   // [31:0] address
    logic [IN_TUSER_W-1:0]    i_s_axis_tuser = '0;   // [0] is_write
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_axis_tdata;        // [0] miss, [1] evict, [2] wback

    // shadow tag store
    t_tag shadow_tag   [ROWS][WAYS];
    t_age shadow_age   [ROWS][WAYS];
    logic shadow_valid [ROWS][WAYS];
    logic shadow_dirty [ROWS][WAYS];

    t_lookup_result pending_lookups[$];

    int       mismatch_count = 0;
    int       requests_sent  = 0;
    int       hit_count      = 0;
    int       miss_count     = 0;
    int       evict_count    = 0;
    int       wb_count       = 0;
    int       cycle_count    = 0;

    // sender burst control
    int       tx_gap_max    = 0;
    int       tx_burst_left = 0;

    // receiver stall control
    t_rx_mode rx_mode      = RX_ALWAYS;
    int       rx_hold_req  = 0;
    int       rx_hold_len  = 0;
    int       rx_hold_seen = 0;
    int       rx_hold_left = 0;
    int       rx_phase     = 0;

    // address generation pools
    t_tag     tag_pool [6];
    int       hot_rows [4];

    set_assoc_cache_tag_lru dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // look up one request in the shadow store and update it
    function automatic t_lookup_result predict_lookup(input logic [ADDR_W-1:0] addr,
                                                      input logic wr);
        t_lookup_result res;
        int unsigned    row;
        t_tag           tg;
        int             hit_way;
        int             victim;
        res     = '0;
        row     = (addr >> SET_OFF) & (ROWS - 1);
        tg      = t_tag'(addr >> TAG_OFF);
        hit_way = -1;
        victim  = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_way < 0 && shadow_valid[row][w] && shadow_tag[row][w] == tg) begin
                hit_way = w;
            end
        end
        // hit: age every other way, refresh the hit way, accumulate dirty
        if (hit_way >= 0) begin
            for (int w = 0; w < WAYS; w++) begin
                if (shadow_age[row][w] != 0) begin
                    shadow_age[row][w] = shadow_age[row][w] - t_age'(1);
                end
            end
            shadow_age[row][hit_way]   = t_age'(WAYS);
            shadow_dirty[row][hit_way] = shadow_dirty[row][hit_way] | wr;
            return res;
        end
        // miss: first empty way, else first way with the smallest age
        res.miss = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
            if (victim < 0 && !shadow_valid[row][w]) begin
                victim = w;
            end
        end
        if (victim < 0) begin
            victim = 0;
            for (int w = 1; w < WAYS; w++) begin
                if (shadow_age[row][w] < shadow_age[row][victim]) begin
                    victim = w;
                end
            end
            res.evict = 1'b1;
            res.wback = shadow_dirty[row][victim];
        end
        shadow_tag[row][victim]   = tg;
        shadow_age[row][victim]   = t_age'(WAYS);
        shadow_valid[row][victim] = 1'b1;
        shadow_dirty[row][victim] = wr;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] make_address(input t_tag tg, input int row,
                                                       input int off);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(tg);
        a = (a << TAG_OFF) | (ADDR_W'(row) << SET_OFF) | ADDR_W'(off);
        return a;
    endfunction

    // mostly hot sets and a small tag pool, so hits and evictions both happen
    function automatic logic [ADDR_W-1:0] pick_address();
        int row;
        if ($urandom_range(0, 4) == 0) begin
            return $urandom();
        end
        row = ($urandom_range(0, 2) != 0) ? hot_rows[$urandom_range(0, 3)]
                                          : $urandom_range(0, ROWS - 1);
        return make_address(tag_pool[$urandom_range(0, 5)], row,
                            $urandom_range(0, OFF_SPAN - 1));
    endfunction

    // present one request and wait for it to be taken
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic wr);
        int gap;
        if (tx_gap_max > 0 && tx_burst_left == 0) begin
            gap           = $urandom_range(1, tx_gap_max);
            tx_burst_left = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= wr;
        @(posedge i_clk);
        while (o_s_axis_tready !== 1'b1) @(posedge i_clk);
        pending_lookups.push_back(predict_lookup(addr, wr));
        requests_sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // fills, write hits, LRU ties and write-backs at the lowest and highest sets, then set 1
    task automatic test_directed();
        t_tag top_tag;
        top_tag    = '1;
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        // empty set must miss even for an all-zero tag
        send_request(make_address('0, 0, 0), 1'b0);
        send_request(make_address('0, 0, 4), 1'b1);
        send_request(make_address('0, 0, 0), 1'b0);
        send_request(make_address(top_tag, 0, OFF_SPAN - 1), 1'b0);
        // tie on age: way 0 goes, and it is dirty
        send_request(make_address(t_tag'(1), 0, 8), 1'b0);
        send_request(make_address(t_tag'(2), 0, 0), 1'b1);
        send_request(make_address(top_tag, 0, 0), 1'b0);
        // oldest way goes, dirty write-back
        send_request(make_address(t_tag'(3), 0, 0), 1'b0);
        send_request(make_address(t_tag'(2), 0, 0), 1'b0);
        // all-ones address in the last set
        send_request('1, 1'b1);
        send_request('1, 1'b1);
        send_request(make_address('0, ROWS - 1, 0), 1'b0);
        send_request(make_address('0, ROWS - 1, 0), 1'b0);
        send_request(make_address(t_tag'(5), ROWS - 1, 0), 1'b0);
        send_request(make_address(t_tag'(6), ROWS - 1, 0), 1'b1);
        send_request(make_address(t_tag'(7), ROWS - 1, 0), 1'b0);
        send_request(make_address('0, 1, 0), 1'b0);
        send_request(make_address('0, 1, 0), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input t_rx_mode mode,
                                       input int gap_max);
        tx_gap_max = gap_max;
        rx_mode    = mode;
        repeat (count) send_request(pick_address(), 1'($urandom_range(0, 1)));
    endtask

    // hold the output long enough for the block to fill and stall its input
    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_mode     = RX_RANDOM;
        rx_hold_len = 300;
        rx_hold_req++;
        repeat (60) send_request(pick_address(), 1'($urandom_range(0, 1)));
        wait_idle();
    endtask

    // back-to-back requests with no stalls on either side
    task automatic test_streaming(input int count);
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        repeat (count) send_request(pick_address(), 1'($urandom_range(0, 1)));
    endtask

    // drive output ready: hold-off first, then the selected stall pattern
    always @(posedge i_clk) begin : drive_ready
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = rx_hold_len;
        end
        rx_phase++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_m_axis_tready <= 1'b1;
                RX_RANDOM: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:   i_m_axis_tready <= ((rx_phase % 11) > 2);
            endcase
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_lookup_result want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result, no request pending: tdata=%h", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_m_axis_tdata[0] !== want.miss) begin
                    $error("miss: expected %b, got %b", want.miss, o_m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[1] !== want.evict) begin
                    $error("evict: expected %b, got %b", want.evict, o_m_axis_tdata[1]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[2] !== want.wback) begin
                    $error("wback: expected %b, got %b", want.wback,
                           o_m_axis_tdata[2]);
                    mismatch_count++;
                end
                if (want.miss) miss_count++; else hit_count++;
                if (want.evict) evict_count++;
                if (want.wback) wb_count++;
            end
        end
    end

    // end the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        for (int r = 0; r < ROWS; r++) begin
            for (int w = 0; w < WAYS; w++) begin
                shadow_tag[r][w]   = '0;
                shadow_age[r][w]   = '0;
                shadow_valid[r][w] = 1'b0;
                shadow_dirty[r][w] = 1'b0;
            end
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++) tag_pool[i] = t_tag'($urandom());
        hot_rows[0] = 0;
        hot_rows[1] = ROWS - 1;
        hot_rows[2] = $urandom_range(0, ROWS - 1);
        hot_rows[3] = $urandom_range(0, ROWS - 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(300, RX_RANDOM, 6);
        test_backpressure();
        test_random_traffic(250, RX_PATTERN, 4);
        test_streaming(220);

        wait_idle();
        if (pending_lookups.size() != 0) begin
            $error("%0d results never arrived", pending_lookups.size());
            mismatch_count++;
        end
        $display("%0d requests: %0d hits, %0d misses, %0d evictions, %0d write-backs",
                 requests_sent, hit_count, miss_count, evict_count, wb_count);
        $display("covered directed LRU cases, bursty input, output stalls and a long hold-off");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sactl_pkg.sv
hw/rtl/sactl_ram.sv
hw/rtl/set_assoc_cache_tag_lru.sv
hw/rtl/sactl_checker.sv
test/set_assoc_cache_tag_lru_tb.sv
